// File: src/thsm_pkg.sv
// Package of shared types and constants for the two-wire humidity sensor master.
`timescale 1ns / 1ps

package thsm_pkg;

	localparam int unsigned HalfW = 16;

	// Request kinds carried by an input word.
	localparam logic [1:0] KIND_TICK     = 2'd0;
	localparam logic [1:0] KIND_TEMP     = 2'd1;
	localparam logic [1:0] KIND_HUMIDITY = 2'd2;

	// Sensor commands.
	localparam logic [7:0] CMD_TEMP     = 8'h03;
	localparam logic [7:0] CMD_HUMIDITY = 8'h05;

	// Last step of the transmission-start pattern and the ack bit position.
	localparam logic [2:0] START_LAST_STEP = 3'd6;
	localparam logic [3:0] BIT_ACK         = 4'd8;

	localparam logic [HalfW-1:0] HALF_RESET = 16'd40;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_START = 5'b00010,
		PH_SEND  = 5'b00100,
		PH_WAIT  = 5'b01000,
		PH_READ  = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [2:0]       step;
		logic [HalfW-1:0] tick;
		logic [3:0]       bitc;
		logic [1:0]       bytec;
		logic [7:0]       shift;
		logic [7:0]       cmd;
		logic [15:0]      value;
		logic [7:0]       chk;
		logic             hum;
		logic             sck;
		logic             dlow;
	} state_t;

endpackage

// File: src/thsm_if.sv
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps

interface thsm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic       data_level;

	modport source (output valid, output kind, output data_level, input ready);
	modport sink (input valid, input kind, input data_level, output ready);
endinterface

interface thsm_res_if;
	logic        valid;
	logic        ready;
	logic        clock_pin;
	logic        data_drive_low;
	logic        busy_res;
	logic        done_res;
	logic [15:0] reading;
	logic [7:0]  check_byte;
	logic        reading_is_humidity;

	modport source (output valid, output clock_pin, output data_drive_low, output busy_res,
		output done_res, output reading, output check_byte, output reading_is_humidity,
		input ready);
	modport sink (input valid, input clock_pin, input data_drive_low, input busy_res,
		input done_res, input reading, input check_byte, input reading_is_humidity,
		output ready);
endinterface

// File: src/thsm_step.sv
// Next-state logic of the sensor protocol engine for one tick.
`timescale 1ns / 1ps

module thsm_step (
	input  thsm_pkg::state_t         cur,
	input  logic [1:0]               kind,
	input  logic                     data_level,
	input  logic [thsm_pkg::HalfW-1:0] half,
	output thsm_pkg::state_t         nxt,
	output logic                     done
);
	import thsm_pkg::*;

	logic [HalfW-1:0] tick_dec;
	logic [HalfW-1:0] per;
	logic             group;

	assign tick_dec = cur.tick - {{(HalfW-1){1'b0}}, 1'b1};
	assign per      = (half == '0) ? {{(HalfW-1){1'b0}}, 1'b1} : half;
	assign group    = (tick_dec == '0);

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		case (cur.phase)
			PH_START: begin
				nxt.tick = group ? per : tick_dec;
				if (group) begin
					case (cur.step)
						3'd0: begin
							nxt.dlow = 1'b0;
							nxt.sck  = 1'b1;
						end
						3'd1: nxt.dlow = 1'b1;
						3'd2: nxt.sck = 1'b0;
						3'd3: nxt.sck = 1'b1;
						3'd4: nxt.dlow = 1'b0;
						3'd5: nxt.sck = 1'b0;
						default: ;
					endcase
					if (cur.step >= START_LAST_STEP) begin
						nxt.phase = PH_SEND;
						nxt.step  = '0;
						nxt.bitc  = '0;
					end else begin
						nxt.step = cur.step + 3'd1;
					end
				end
			end
			PH_SEND: begin
				nxt.tick = group ? per : tick_dec;
				if (group) begin
					if (cur.step == '0) begin
						if (cur.bitc < BIT_ACK)
							nxt.dlow = ~cur.cmd[3'd7 - cur.bitc[2:0]];
						nxt.sck  = 1'b1;
						nxt.step = 3'd1;
					end else begin
						nxt.sck  = 1'b0;
						nxt.step = '0;
						if (cur.bitc >= BIT_ACK) begin
							nxt.phase = PH_WAIT;
							nxt.bitc  = '0;
						end else begin
							nxt.bitc = cur.bitc + 4'd1;
						end
					end
				end
			end
			PH_WAIT: begin
				if (!data_level) begin
					nxt.phase = PH_READ;
					nxt.step  = '0;
					nxt.bitc  = '0;
					nxt.bytec = '0;
					nxt.tick  = per;
				end
			end
			PH_READ: begin
				nxt.tick = group ? per : tick_dec;
				if (group) begin
					if (cur.step == '0) begin
						if (cur.bitc < BIT_ACK)
							nxt.shift = {cur.shift[6:0], data_level};
						else
							nxt.dlow = (cur.bytec < 2'd2);
						nxt.sck  = 1'b1;
						nxt.step = 3'd1;
					end else begin
						nxt.sck  = 1'b0;
						nxt.step = '0;
						if (cur.bitc < BIT_ACK) begin
							nxt.bitc = cur.bitc + 4'd1;
						end else begin
							nxt.dlow = 1'b0;
							nxt.bitc = '0;
							case (cur.bytec)
								2'd0: begin
									nxt.value = {cur.shift, cur.value[7:0]};
									nxt.bytec = 2'd1;
								end
								2'd1: begin
									nxt.value = {cur.value[15:8], cur.shift};
									nxt.bytec = 2'd2;
								end
								default: begin
									nxt.chk   = cur.shift;
									nxt.bytec = '0;
									nxt.phase = PH_IDLE;
									done      = 1'b1;
								end
							endcase
						end
					end
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
				if (kind == KIND_TEMP || kind == KIND_HUMIDITY) begin
					nxt.cmd   = (kind == KIND_TEMP) ? CMD_TEMP : CMD_HUMIDITY;
					nxt.hum   = (kind == KIND_HUMIDITY);
					nxt.phase = PH_START;
					nxt.step  = '0;
					nxt.bitc  = '0;
					nxt.bytec = '0;
					nxt.tick  = per;
				end
			end
		endcase
	end

endmodule

// File: src/two_wire_humidity_sensor_master_core.sv
// Top level of the two-wire humidity and temperature sensor master.
`timescale 1ns / 1ps

// Each request word is one tick of the sensor protocol and yields exactly one result
// word, which shows the pin levels, status and readout after that tick. A start
// request while idle (kind 1 for temperature, kind 2 for humidity) sends the start
// pattern, shifts out the command with an ack clock, waits for the sensor to pull DATA
// low, then reads two data bytes and a checksum byte; start requests while busy are
// ignored. Pin changes are spaced by the half-period register, where zero acts as one.
// A word is taken in every cycle: the protocol state advances in a single registered
// step and the result sits in one output register, so the request side stays ready as
// long as the result register is empty or being emptied in the same cycle. The result
// word of an accepted request is valid from the cycle after it. The half-period register
// should only be written while no word is waiting in the result register.
module two_wire_humidity_sensor_master_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [thsm_pkg::HalfW-1:0]  cfg_wdata,
	thsm_req_if.sink                    req,
	thsm_res_if.source                  res
);
	import thsm_pkg::*;

	logic [HalfW-1:0] half_q;
	state_t           state_q;
	state_t           state_nxt;
	logic             done_nxt;
	logic             take;
	logic             out_valid_q;

	// Result register payload.
	logic        sck_q;
	logic        dlow_q;
	logic        busy_q;
	logic        done_q;
	logic [15:0] value_q;
	logic [7:0]  chk_q;
	logic        hum_q;

	// The request side moves whenever the result register will be free next cycle.
	assign req.ready = !out_valid_q || res.ready;
	assign take      = req.valid && req.ready;

	thsm_step u_step (
		.cur        (state_q),
		.kind       (req.kind),
		.data_level (req.data_level),
		.half       (half_q),
		.nxt        (state_nxt),
		.done       (done_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	// Protocol state only advances on an accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, step: '0, tick: '0, bitc: '0, bytec: '0,
				shift: '0, cmd: '0, value: '0, chk: '0, hum: 1'b0, sck: 1'b0,
				dlow: 1'b0};
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sck_q   <= state_nxt.sck;
			dlow_q  <= state_nxt.dlow;
			busy_q  <= (state_nxt.phase != PH_IDLE);
			done_q  <= done_nxt;
			value_q <= state_nxt.value;
			chk_q   <= state_nxt.chk;
			hum_q   <= state_nxt.hum;
		end
	end

	assign res.valid               = out_valid_q;
	assign res.clock_pin           = sck_q;
	assign res.data_drive_low      = dlow_q;
	assign res.busy_res            = busy_q;
	assign res.done_res            = done_q;
	assign res.reading             = value_q;
	assign res.check_byte          = chk_q;
	assign res.reading_is_humidity = hum_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the two-wire humidity sensor master core.
`timescale 1ns / 1ps

// Every request word is one protocol tick, and every tick gives exactly one result word.
// A small scoreboard class keeps its own model of the sensor master. It has the phase,
// the tick countdown, the bit and byte positions, the receive shift register and the
// pin levels. For each accepted request word the scoreboard works out the result word
// that the block must return, and it queues that word. A monitor compares each
// accepted result word with the oldest word in the queue, one field at a time.
//
// The stimulus has three parts. First there is a short directed part, which starts a
// measurement at the reset half period and then drops the half period to one. Then a
// half period of zero (which acts as one) and the largest half period are written, and
// a whole measurement runs at the smallest one. Last come random phases at small half
// periods, where most measurements finish in a few hundred ticks. The half-period
// register is written only when the request side is stalled and every expected word
// has arrived.

module tb;
	import thsm_pkg::*;

	// Kind 3 is not a defined request, so the block treats it as a plain tick.
	localparam logic [1:0] KindUnused = 2'd3;

	localparam int unsigned CycleLimit = 1_000_000;
	localparam int unsigned WordsPerPhase = 140;
	localparam int unsigned HalfPlan [8] = '{1, 2, 0, 3, 1, 2, 5, 1};

	typedef struct packed {
		logic        clock_pin;
		logic        data_drive_low;
		logic        busy;
		logic        done;
		logic [15:0] reading;
		logic [7:0]  chk_byte;
		logic        is_humidity;
	} sensor_word_t;

	class sensor_scoreboard;
		logic [15:0]  half_period;
		phase_t       proto_phase;
		logic [3:0]   pin_step;
		logic [15:0]  tick_left;
		logic [3:0]   bit_idx;
		logic [1:0]   byte_idx;
		logic [7:0]   rx_shift;
		logic [7:0]   cmd_byte;
		logic [15:0]  raw_value;
		logic [7:0]   crc_byte;
		logic         is_humidity;
		logic         sck_q;
		logic         dlow_q;
		sensor_word_t expected_q[$];
		int unsigned  words_checked;
		int unsigned  mismatches;
		int unsigned  readings_done;

		function new();
			half_period = HALF_RESET;
			proto_phase = PH_IDLE;
			pin_step = '0;
			tick_left = '0;
			bit_idx = '0;
			byte_idx = '0;
			rx_shift = '0;
			cmd_byte = '0;
			raw_value = '0;
			crc_byte = '0;
			is_humidity = 1'b0;
			sck_q = 1'b0;
			dlow_q = 1'b0;
			words_checked = 0;
			mismatches = 0;
			readings_done = 0;
		endfunction

		function void set_half(logic [15:0] value);
			half_period = value;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Advance the model by one tick and queue the result word it must produce.
		function void note_request(logic [1:0] kind, logic level);
			logic [15:0]  reload;
			logic         done;
			sensor_word_t w;

			reload = (half_period == '0) ? 16'd1 : half_period;
			done = 1'b0;
			case (proto_phase)
				PH_START, PH_SEND, PH_READ: begin
					tick_left = tick_left - 16'd1;
					if (tick_left == '0) begin
						tick_left = reload;
						if (proto_phase == PH_START) begin
							case (pin_step)
								4'd0: begin
									dlow_q = 1'b0;
									sck_q = 1'b1;
								end
								4'd1: dlow_q = 1'b1;
								4'd2: sck_q = 1'b0;
								4'd3: sck_q = 1'b1;
								4'd4: dlow_q = 1'b0;
								4'd5: sck_q = 1'b0;
								default: ;
							endcase
							if (pin_step >= START_LAST_STEP) begin
								proto_phase = PH_SEND;
								pin_step = '0;
								bit_idx = '0;
							end else begin
								pin_step = pin_step + 4'd1;
							end
						end else if (proto_phase == PH_SEND) begin
							if (pin_step == '0) begin
								// A one is sent by releasing DATA, a zero by pulling it low.
								if (bit_idx < BIT_ACK)
									dlow_q = ((cmd_byte & (8'h80 >> bit_idx)) == 8'h00);
								sck_q = 1'b1;
								pin_step = 4'd1;
							end else begin
								sck_q = 1'b0;
								pin_step = '0;
								if (bit_idx >= BIT_ACK) begin
									proto_phase = PH_WAIT;
									bit_idx = '0;
								end else begin
									bit_idx = bit_idx + 4'd1;
								end
							end
						end else begin
							if (pin_step == '0) begin
								// Data bits are taken as SCK rises; an ack clock follows each byte.
								if (bit_idx < BIT_ACK)
									rx_shift = {rx_shift[6:0], level};
								else
									dlow_q = (byte_idx < 2'd2);
								sck_q = 1'b1;
								pin_step = 4'd1;
							end else begin
								sck_q = 1'b0;
								pin_step = '0;
								if (bit_idx < BIT_ACK) begin
									bit_idx = bit_idx + 4'd1;
								end else begin
									dlow_q = 1'b0;
									bit_idx = '0;
									case (byte_idx)
										2'd0: begin
											raw_value[15:8] = rx_shift;
											byte_idx = 2'd1;
										end
										2'd1: begin
											raw_value[7:0] = rx_shift;
											byte_idx = 2'd2;
										end
										default: begin
											crc_byte = rx_shift;
											byte_idx = 2'd0;
											proto_phase = PH_IDLE;
											done = 1'b1;
										end
									endcase
								end
							end
						end
					end
				end
				PH_WAIT: begin
					if (!level) begin
						proto_phase = PH_READ;
						pin_step = '0;
						bit_idx = '0;
						byte_idx = '0;
						tick_left = reload;
					end
				end
				default: begin
					proto_phase = PH_IDLE;
					if (kind == KIND_TEMP || kind == KIND_HUMIDITY) begin
						cmd_byte = (kind == KIND_TEMP) ? CMD_TEMP : CMD_HUMIDITY;
						is_humidity = (kind == KIND_HUMIDITY);
						proto_phase = PH_START;
						pin_step = '0;
						bit_idx = '0;
						byte_idx = '0;
						tick_left = reload;
					end
				end
			endcase
			w.clock_pin = sck_q;
			w.data_drive_low = dlow_q;
			w.busy = (proto_phase != PH_IDLE);
			w.done = done;
			w.reading = raw_value;
			w.chk_byte = crc_byte;
			w.is_humidity = is_humidity;
			expected_q.push_back(w);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(sensor_word_t got);
			sensor_word_t want;

			if (expected_q.size() == 0) begin
				$error("result word arrived with no expectation waiting");
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("clock_pin", 16'(want.clock_pin), 16'(got.clock_pin));
			compare_field("data_drive_low", 16'(want.data_drive_low), 16'(got.data_drive_low));
			compare_field("busy_res", 16'(want.busy), 16'(got.busy));
			compare_field("done_res", 16'(want.done), 16'(got.done));
			compare_field("reading", want.reading, got.reading);
			compare_field("check_byte", 16'(want.chk_byte), 16'(got.chk_byte));
			compare_field("reading_is_humidity", 16'(want.is_humidity), 16'(got.is_humidity));
			words_checked++;
			if (want.done)
				readings_done++;
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [HalfW-1:0]     cfg_wdata;
	bit                   idle_on = 1'b1;
	int unsigned          stall_left = 0;
	int unsigned          cycle_count = 0;
	sensor_scoreboard     sb = new();

	thsm_req_if req_ch();
	thsm_res_if res_ch();

	two_wire_humidity_sensor_master_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The run is cut off here if the block stops handing over words.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("** two_wire_humidity_sensor_master_core: FAILED **");
			$finish;
		end
	end

	// The result side stalls in random bursts while idling is allowed.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			res_ch.ready <= 1'b0;
			stall_left = $urandom_range(1, 13) - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// The monitor samples at the clock edge, so it sees the values that the handshake used.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			sb.check_result({res_ch.clock_pin, res_ch.data_drive_low, res_ch.busy_res,
				res_ch.done_res, res_ch.reading, res_ch.check_byte,
				res_ch.reading_is_humidity});
	end

	// Present one request word and hold it until it is accepted. A random gap may
	// come first while idling is allowed.
	task automatic send_word(input logic [1:0] kind, input logic level);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.data_level <= level;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(kind, level);
	endtask

	// Plain ticks are the most common words. Start requests come often enough that
	// a new measurement begins soon after the last one ends. While the sensor is
	// awaited, DATA stays high most of the time, so the waits vary in length.
	task automatic send_random_word();
		logic [1:0]  kind;
		logic        level;
		int unsigned pick;

		pick = $urandom_range(0, 99);
		if (pick < 80)
			kind = KIND_TICK;
		else if (pick < 86)
			kind = KindUnused;
		else if (pick < 93)
			kind = KIND_TEMP;
		else
			kind = KIND_HUMIDITY;
		if (sb.proto_phase == PH_WAIT)
			level = ($urandom_range(0, 3) != 0);
		else
			level = 1'($urandom_range(0, 1));
		send_word(kind, level);
	endtask

	task automatic run_until_idle();
		do send_random_word(); while (sb.proto_phase != PH_IDLE);
	endtask

	// Stop sending and wait until every expected word has come back. Only then is the
	// half-period register written.
	task automatic set_half_period(input logic [15:0] value);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_half(value);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_TICK;
		req_ch.data_level = 1'b1;
		res_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the unused kind while idle, both DATA levels, and a temperature
		// start at the reset half period. After the start come start requests, which the
		// block must ignore while it is busy. Once the first pin change has been seen,
		// the half period drops to one so that the measurement ends soon.
		send_word(KIND_TICK, 1'b1);
		send_word(KindUnused, 1'b0);
		send_word(KIND_TICK, 1'b0);
		send_word(KindUnused, 1'b1);
		send_word(KIND_TEMP, 1'b1);
		send_word(KIND_HUMIDITY, 1'b0);
		send_word(KIND_TEMP, 1'b0);
		send_word(KindUnused, 1'b1);
		repeat (40) send_random_word();
		set_half_period(16'd1);
		run_until_idle();

		// A half period of zero must behave exactly as a half period of one.
		set_half_period(16'd0);
		send_word(KIND_HUMIDITY, 1'b1);
		send_word(KIND_HUMIDITY, 1'b0);
		run_until_idle();

		// Largest half period, written while the block is idle. Plain ticks and the
		// unused kind must leave it idle. A whole measurement then runs at one.
		set_half_period(16'hFFFF);
		send_word(KIND_TICK, 1'b1);
		send_word(KindUnused, 1'b0);
		send_word(KIND_TICK, 1'b0);
		set_half_period(16'd1);
		send_word(KIND_HUMIDITY, 1'b1);
		run_until_idle();

		// Random phases at small half periods. Some of these writes fall in the middle
		// of a measurement. The last two phases run with no idling on either side.
		for (int p = 0; p < 8; p++) begin
			idle_on = (p < 6);
			set_half_period(16'(HalfPlan[p]));
			repeat (WordsPerPhase) send_random_word();
		end

		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (5) @(posedge clk);

		$display("Checked %0d result words, including %0d completed readings.",
			sb.words_checked, sb.readings_done);
		$display("Half-period settings from 0 to 65535 were written, with and without idling.");
		if (sb.mismatches == 0)
			$display("** two_wire_humidity_sensor_master_core: PASSED **");
		else
			$display("** two_wire_humidity_sensor_master_core: FAILED **");
		$finish;
	end

endmodule
